@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the convolver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/sfc_pkg.sv @@
`default_nettype none
package sfc_pkg;

  localparam int MAX_RADIUS  = 3;
  localparam int WIN_LEN     = 2 * MAX_RADIUS + 1;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS;
  localparam int MAX_WIDTH   = 2048;
  localparam int PIX_W       = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int RAD_W       = 2;
  localparam int WID_W       = 12;
  localparam int TAP_W       = 21;
  localparam int PACK_W      = 63;
  localparam int NUM_PACKS   = 5;
  localparam int ACC_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int SLOT_W      = $clog2(STORE_ROWS + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS       = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_COEF_PACK_0  = 3'd3,
    CFG_COEF_PACK_1  = 3'd4,
    CFG_COEF_PACK_2  = 3'd5,
    CFG_COEF_PACK_3  = 3'd6,
    CFG_COEF_PACK_4  = 3'd7
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_PACKS-1:0][PACK_W-1:0] coef_packs_t;

  // One column job: everything the back end needs to filter and emit one column.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              pass;
    pix_t              pix;
    pix_t [WIN_LEN-1:0] ops;
    logic              emit;
    logic              last_row;
    logic              last_job;
  } job_t;

  // A radius of zero behaves as one.
  function automatic logic [RAD_W-1:0] eff_radius(logic [RAD_W-1:0] r);
    return (r == '0) ? RAD_W'(1) : r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/separable_fir_2d_convolver_core.sv @@
`default_nettype none
// Separable 2-D FIR for 8-bit raster pixels, radius 1..3, rows up to 2048 wide.
// Input channel: in_valid/in_stall carry one source pixel per word, raster order.
// Output channel: out_valid/out_stall carry one filtered pixel per word with its
// row and column; out_last_of_run marks the last result caused by one input word.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// write only while the block is idle.
// Throughput: one pixel per clock inside a row while the job queue has room. The
// last pixel of a row makes R+1 columns ready, so the input stalls until all are
// queued. On the last row each column gives R+1 results, one per output cycle
// while out_stall is low, so the output port sets the pace. Pipeline: a pixel's
// result passes the 7-stage horizontal and 7-stage vertical multiply-accumulate
// chains and the line store read.
// Stall: the back end freezes while a result waits; the front keeps taking pixels
// until its 4-entry job queue fills.
// Reset (synchronous, rst_n low) clears counters, the pixel window and all valid
// flags and restores default registers; the line store is not cleared.
module separable_fir_2d_convolver_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfc_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfc_pkg::ROW_W-1:0]         out_row,
  output logic [sfc_pkg::COL_W-1:0]         out_col,
  output logic [sfc_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                              out_last_of_run,
  input  logic                              cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfc_pkg::PACK_W-1:0]        cfg_wdata
);

  logic [sfc_pkg::RAD_W-1:0] radius_r;
  logic [sfc_pkg::WID_W-1:0] width_r;
  logic [sfc_pkg::ROW_W-1:0] height_r;
  sfc_pkg::coef_packs_t      coef_r;

  logic          q_full, q_empty, q_push, q_pop;
  sfc_pkg::job_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= sfc_pkg::RAD_W'(1);
      width_r  <= sfc_pkg::WID_W'(640);
      height_r <= sfc_pkg::ROW_W'(480);
      coef_r   <= '0;
    end else if (cfg_we) begin
      case (sfc_pkg::cfg_idx_t'(cfg_index))
        sfc_pkg::CFG_RADIUS:       radius_r  <= cfg_wdata[sfc_pkg::RAD_W-1:0];
        sfc_pkg::CFG_IMAGE_WIDTH:  width_r   <= cfg_wdata[sfc_pkg::WID_W-1:0];
        sfc_pkg::CFG_IMAGE_HEIGHT: height_r  <= cfg_wdata[sfc_pkg::ROW_W-1:0];
        sfc_pkg::CFG_COEF_PACK_0:  coef_r[0] <= cfg_wdata;
        sfc_pkg::CFG_COEF_PACK_1:  coef_r[1] <= cfg_wdata;
        sfc_pkg::CFG_COEF_PACK_2:  coef_r[2] <= cfg_wdata;
        sfc_pkg::CFG_COEF_PACK_3:  coef_r[3] <= cfg_wdata;
        sfc_pkg::CFG_COEF_PACK_4:  coef_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .radius       (radius_r),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_din)
  );

  sfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  sfc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .radius          (radius_r),
    .coefs           (coef_r),
    .q_empty         (q_empty),
    .q_job           (q_dout),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_pixel_out   (out_pixel_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

@@ rtl/sfc_ram.sv @@
`default_nettype none
module sfc_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same address return the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sfc_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module sfc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfc_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic [sfc_pkg::RAD_W-1:0]       radius,
  input  logic [sfc_pkg::WID_W-1:0]       image_width,
  input  logic [sfc_pkg::ROW_W-1:0]       image_height,
  input  logic                            q_full,
  output logic                            q_push,
  output sfc_pkg::job_t                   q_job
);

  sfc_pkg::pix_t [sfc_pkg::WIN_LEN-1:0] win_r;
  logic [sfc_pkg::COL_W-1:0]  col_r, col_nxt, px_r, x, c, w_last;
  logic [sfc_pkg::ROW_W-1:0]  row_r, row_nxt, py_r, y, h_eff, h_last;
  logic [sfc_pkg::SLOT_W-1:0] pslot_r;
  logic [sfc_pkg::RAD_W-1:0]  pd_r, er;
  logic [sfc_pkg::WID_W-1:0]  ntaps, w_eff;
  logic pv_r, plc_r, plr_r;
  logic last_col, last_row, job_last, accept;

  // Slot of a row in the line store: row modulo 2R. Modulo six goes through
  // modulo three (sum of base-four digits) and the parity bit.
  function automatic logic [sfc_pkg::SLOT_W-1:0] row_slot(logic [sfc_pkg::ROW_W-1:0] yy,
                                                          logic [sfc_pkg::RAD_W-1:0] r);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] m3;
    s = '0;
    for (int i = 0; i < sfc_pkg::ROW_W / 2; i++) begin
      s = s + 5'(yy[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    case (t) inside
      3'd0, 3'd3, 3'd6: m3 = 2'd0;
      3'd1, 3'd4, 3'd7: m3 = 2'd1;
      default:          m3 = 2'd2;
    endcase
    case (r)
      2'd1:    return {2'b00, yy[0]};
      2'd2:    return {1'b0, yy[1:0]};
      default: return (m3[0] == yy[0]) ? {1'b0, m3} : 3'({1'b0, m3} + 3'd3);
    endcase
  endfunction

  always_comb begin
    er     = sfc_pkg::eff_radius(radius);
    ntaps  = sfc_pkg::WID_W'({er, 1'b1});
    if (image_width < ntaps) begin
      w_eff = ntaps;
    end else if (image_width > sfc_pkg::WID_W'(sfc_pkg::MAX_WIDTH)) begin
      w_eff = sfc_pkg::WID_W'(sfc_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    w_last = sfc_pkg::COL_W'(w_eff - 1'b1);
    h_eff  = (image_height < sfc_pkg::ROW_W'(ntaps)) ? sfc_pkg::ROW_W'(ntaps) : image_height;
    h_last = h_eff - 1'b1;
    x      = (col_r < w_last) ? col_r : w_last;
    y      = (row_r < h_last) ? row_r : h_last;
    last_col = (x == w_last);
    last_row = (y == h_last);
    col_nxt  = last_col ? '0 : x + 1'b1;
    row_nxt  = last_col ? (last_row ? '0 : y + 1'b1) : row_r;
  end

  // Job for column x-d of the pending word; at a row end d runs from R down to 0.
  always_comb begin
    c = px_r - sfc_pkg::COL_W'(pd_r);
    q_job.col      = c;
    q_job.row      = py_r;
    q_job.slot     = pslot_r;
    q_job.pass     = (c < sfc_pkg::COL_W'(er)) || ({1'b0, c} >= w_eff - sfc_pkg::WID_W'(er));
    q_job.pix      = win_r[{1'b0, pd_r}];
    for (int k = 0; k < sfc_pkg::WIN_LEN; k++) begin
      if (k <= 2 * er) begin
        q_job.ops[k] = win_r[sfc_pkg::SLOT_W'(2 * er - k)];
      end else begin
        q_job.ops[k] = '0;
      end
    end
    q_job.emit     = (py_r >= sfc_pkg::ROW_W'(er));
    q_job.last_row = plr_r;
    job_last       = !plc_r || (pd_r == '0);
    q_job.last_job = job_last;
  end

  assign q_push   = pv_r && !q_full;
  assign in_stall = pv_r && !(q_push && job_last);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else begin
      if (q_push) begin
        if (job_last) begin
          if (!accept) begin
            pv_r <= 1'b0;
          end
        end else begin
          pd_r <= pd_r - 1'b1;
        end
      end
      if (accept) begin
        win_r   <= {win_r[sfc_pkg::WIN_LEN-2:0], in_pixel_in};
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        pv_r    <= last_col || (x >= sfc_pkg::COL_W'(er));
        pd_r    <= er;
        px_r    <= x;
        py_r    <= y;
        pslot_r <= row_slot(y, er);
        plc_r   <= last_col;
        plr_r   <= last_row;
      end
    end
  end

  `SFC_ASSERT_NEXT(a_pending_held, clk, rst_n, pv_r && !q_push, pv_r)

endmodule
`default_nettype wire

@@ rtl/sfc_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module sfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfc_pkg::job_t din,
  input  logic          pop,
  output sfc_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  sfc_pkg::job_t mem_r [sfc_pkg::QUEUE_DEPTH];
  logic [sfc_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [sfc_pkg::QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= din;
        wp_r        <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign dout  = mem_r[rp_r];
  assign full  = (cnt_r == (sfc_pkg::QPTR_W+1)'(sfc_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);

  `SFC_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
  `SFC_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty)

endmodule
`default_nettype wire

@@ rtl/sfc_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module sfc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sfc_pkg::RAD_W-1:0]    radius,
  input  sfc_pkg::coef_packs_t         coefs,
  input  logic                         q_empty,
  input  sfc_pkg::job_t                q_job,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfc_pkg::ROW_W-1:0]    out_row,
  output logic [sfc_pkg::COL_W-1:0]    out_col,
  output logic [sfc_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                         out_last_of_run
);

  localparam int NS = sfc_pkg::WIN_LEN;

  typedef logic signed [sfc_pkg::ACC_W-1:0] acc_t;
  typedef sfc_pkg::pix_t [sfc_pkg::STORE_ROWS-1:0] store_col_t;

  function automatic logic signed [sfc_pkg::TAP_W-1:0] tap_get(sfc_pkg::coef_packs_t p, int g);
    return p[g / 3][sfc_pkg::TAP_W * (g % 3) +: sfc_pkg::TAP_W];
  endfunction

  function automatic acc_t mac(acc_t acc, logic signed [sfc_pkg::TAP_W-1:0] t,
                               sfc_pkg::pix_t p);
    logic signed [sfc_pkg::TAP_W+sfc_pkg::PIX_W:0] prod;
    prod = t * $signed({1'b0, p});
    return acc + sfc_pkg::ACC_W'(prod);
  endfunction

  function automatic sfc_pkg::pix_t clamp_q16(acc_t s);
    if (s < 0) begin
      return '0;
    end
    if (|s[sfc_pkg::ACC_W-1:sfc_pkg::FRAC_W+sfc_pkg::PIX_W]) begin
      return '1;
    end
    return s[sfc_pkg::FRAC_W +: sfc_pkg::PIX_W];
  endfunction

  // Vertical operand i: stored rows first, then the fresh horizontal value.
  function automatic sfc_pkg::pix_t vop(int i, store_col_t st, sfc_pkg::pix_t h,
                                        logic [sfc_pkg::SLOT_W-1:0] two_r);
    if (i < sfc_pkg::STORE_ROWS && sfc_pkg::SLOT_W'(i) < two_r) begin
      return st[sfc_pkg::SLOT_W'(i)];
    end
    if (sfc_pkg::SLOT_W'(i) == two_r) begin
      return h;
    end
    return '0;
  endfunction

  logic [sfc_pkg::RAD_W-1:0]  er;
  logic [sfc_pkg::SLOT_W-1:0] two_r;
  logic adv;

  sfc_pkg::job_t hjob_r [0:NS];
  logic          hv_r   [0:NS];
  acc_t          hacc_r [0:NS];

  sfc_pkg::job_t cjob_r;
  logic          cv_r;
  sfc_pkg::pix_t ch_r;

  sfc_pkg::job_t vjob_r [0:NS];
  logic          vv_r   [0:NS];
  sfc_pkg::pix_t vh_r   [0:NS];
  acc_t          vacc_r [0:NS];
  store_col_t    vst_r  [1:NS];
  store_col_t    stv    [0:NS];

  sfc_pkg::pix_t q [sfc_pkg::STORE_ROWS];
  store_col_t    st_cur;

  logic                            ov_r, ojl_r;
  logic [sfc_pkg::ROW_W-1:0]       orow_r;
  logic [sfc_pkg::COL_W-1:0]       ocol_r;
  sfc_pkg::pix_t [sfc_pkg::MAX_RADIUS:0] ovals_r, vals;
  logic [sfc_pkg::RAD_W-1:0]       oidx_r, olast_r;

  assign er    = sfc_pkg::eff_radius(radius);
  assign two_r = {er, 1'b0};
  assign adv   = !ov_r || (!out_stall && (oidx_r == olast_r));
  assign q_pop = adv && !q_empty;

  // Line store: one bank per slot, all banks read at the job's column.
  for (genvar b = 0; b < sfc_pkg::STORE_ROWS; b++) begin : g_bank
    sfc_ram #(
      .DEPTH  (sfc_pkg::MAX_WIDTH),
      .DATA_W (sfc_pkg::PIX_W)
    ) u_ram (
      .clk   (clk),
      .we    (adv && cv_r && (cjob_r.slot == sfc_pkg::SLOT_W'(b))),
      .waddr (cjob_r.col),
      .wdata (ch_r),
      .re    (adv),
      .raddr (cjob_r.col),
      .rdata (q[b])
    );
  end

  // Rotate the banks so that entry k holds row y-2R+k.
  always_comb begin
    logic [sfc_pkg::SLOT_W:0] idx;
    for (int k = 0; k < sfc_pkg::STORE_ROWS; k++) begin
      idx = (sfc_pkg::SLOT_W+1)'(vjob_r[0].slot) + (sfc_pkg::SLOT_W+1)'(k);
      if (idx >= {1'b0, two_r}) begin
        idx = idx - {1'b0, two_r};
      end
      st_cur[k] = (sfc_pkg::SLOT_W'(k) < two_r) ? q[idx[sfc_pkg::SLOT_W-1:0]] : '0;
    end
    stv[0] = st_cur;
    for (int i = 1; i <= NS; i++) begin
      stv[i] = vst_r[i];
    end
  end

  // Results of the column leaving the vertical stages.
  always_comb begin
    if (vjob_r[NS].row < sfc_pkg::ROW_W'(two_r)) begin
      vals[0] = stv[NS][sfc_pkg::SLOT_W'(er)];
    end else begin
      vals[0] = clamp_q16(vacc_r[NS]);
    end
    for (int j = 1; j <= sfc_pkg::MAX_RADIUS; j++) begin
      if (sfc_pkg::RAD_W'(j) < er) begin
        vals[j] = stv[NS][sfc_pkg::SLOT_W'(er) + sfc_pkg::SLOT_W'(j)];
      end else if (sfc_pkg::RAD_W'(j) == er) begin
        vals[j] = vh_r[NS];
      end else begin
        vals[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        hv_r[i] <= 1'b0;
        vv_r[i] <= 1'b0;
      end
      cv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (adv) begin
        hv_r[0] <= !q_empty;
        for (int i = 1; i <= NS; i++) begin
          hv_r[i] <= hv_r[i-1];
          vv_r[i] <= vv_r[i-1];
        end
        cv_r    <= hv_r[NS];
        vv_r[0] <= cv_r;
        ov_r    <= vv_r[NS] && vjob_r[NS].emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hjob_r[0] <= q_job;
      hacc_r[0] <= '0;
      for (int i = 1; i <= NS; i++) begin
        hjob_r[i] <= hjob_r[i-1];
        hacc_r[i] <= mac(hacc_r[i-1], tap_get(coefs, i - 1), hjob_r[i-1].ops[i-1]);
      end
      cjob_r <= hjob_r[NS];
      ch_r   <= hjob_r[NS].pass ? hjob_r[NS].pix : clamp_q16(hacc_r[NS]);
      vjob_r[0] <= cjob_r;
      vh_r[0]   <= ch_r;
      vacc_r[0] <= '0;
      for (int i = 1; i <= NS; i++) begin
        vjob_r[i] <= vjob_r[i-1];
        vh_r[i]   <= vh_r[i-1];
        vst_r[i]  <= stv[i-1];
        vacc_r[i] <= mac(vacc_r[i-1], tap_get(coefs, NS + i - 1),
                         vop(i - 1, stv[i-1], vh_r[i-1], two_r));
      end
      orow_r  <= vjob_r[NS].row - sfc_pkg::ROW_W'(er);
      ocol_r  <= vjob_r[NS].col;
      ovals_r <= vals;
      ojl_r   <= vjob_r[NS].last_job;
      oidx_r  <= '0;
      olast_r <= vjob_r[NS].last_row ? er : '0;
    end else if (!out_stall) begin
      oidx_r <= oidx_r + 1'b1;
    end
  end

  assign out_valid       = ov_r;
  assign out_row         = orow_r + sfc_pkg::ROW_W'(oidx_r);
  assign out_col         = ocol_r;
  assign out_pixel_out   = ovals_r[oidx_r];
  assign out_last_of_run = ojl_r && (oidx_r == olast_r);

  `SFC_ASSERT_IMP(a_idx_in_range, clk, rst_n, ov_r, oidx_r <= olast_r)
  `SFC_ASSERT_IMP(a_wr_slot, clk, rst_n, cv_r, cjob_r.slot < two_r)

endmodule
`default_nettype wire
